[rtl/assert_macros.svh]
// Assertion macros used by rtp_pack_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/rtp_pkg.sv]
// Types and constants of the raster to tile pixel packer.
`timescale 1ns / 1ps
package rtp_pkg;
	localparam int PIX_W    = 8;
	localparam int ADDR_W   = 21;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 3;
	localparam int DIM_W    = 11;
	localparam logic [ADDR_W-1:0] HEADER_BYTES = 21'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH_IS_16  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT_IS_16 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT      = 3'd4;

	localparam logic [1:0] DEPTH_2BPP = 2'd0;
	localparam logic [1:0] DEPTH_4BPP = 2'd1;
	localparam logic [1:0] DEPTH_8BPP = 2'd2;

	typedef struct packed {
		logic [1:0]       pixel_depth_mode;
		logic             tile_width_is_16;
		logic             tile_height_is_16;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} cfg_t;

	// log2 of bits per pixel; the unused mode code packs 8 bits
	function automatic logic [1:0] depth_log2(input logic [1:0] mode);
		logic [1:0] r;
		case (mode)
			DEPTH_2BPP: r = 2'd1;
			DEPTH_4BPP: r = 2'd2;
			default:    r = 2'd3;
		endcase
		return r;
	endfunction
endpackage

[rtl/rtp_px_if.sv]
// Pixel input channel.
`timescale 1ns / 1ps
interface rtp_px_if;
	logic                     valid;
	logic                     ready;
	logic [rtp_pkg::PIX_W-1:0] pixel_color;
	logic                     first_pixel;

	modport source (output valid, output pixel_color, output first_pixel, input ready);
	modport sink   (input valid, input pixel_color, input first_pixel, output ready);
endinterface

[rtl/rtp_byte_if.sv]
// Packed byte output channel.
`timescale 1ns / 1ps
interface rtp_byte_if;
	logic                      valid;
	logic                      ready;
	logic [rtp_pkg::PIX_W-1:0]  byte_value;
	logic [rtp_pkg::ADDR_W-1:0] byte_address;
	logic                      last_byte;

	modport source (output valid, output byte_value, output byte_address, output last_byte,
		input ready);
	modport sink   (input valid, input byte_value, input byte_address, input last_byte,
		output ready);
endinterface

[rtl/rtp_cfg_regs.sv]
// Configuration register file.
`timescale 1ns / 1ps
module rtp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rtp_pkg::CFG_W-1:0]     cfg_wdata,
	output rtp_pkg::cfg_t                 cfg
);
	import rtp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_depth_mode  <= DEPTH_4BPP;
			cfg_q.tile_width_is_16  <= 1'b0;
			cfg_q.tile_height_is_16 <= 1'b0;
			cfg_q.image_width       <= 11'd64;
			cfg_q.image_height      <= 11'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PIXEL_DEPTH_MODE:  cfg_q.pixel_depth_mode  <= cfg_wdata[1:0];
				REG_TILE_WIDTH_IS_16:  cfg_q.tile_width_is_16  <= cfg_wdata[0];
				REG_TILE_HEIGHT_IS_16: cfg_q.tile_height_is_16 <= cfg_wdata[0];
				REG_IMAGE_WIDTH:       cfg_q.image_width       <= cfg_wdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT:      cfg_q.image_height      <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[rtl/rtp_pack_core.sv]
// Input register, raster position tracking, packing and address datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtp_pack_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rtp_pkg::cfg_t cfg,
	rtp_px_if.sink        pixel_in,
	rtp_byte_if.source    byte_out
);
	import rtp_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = CW + 1;
	localparam int HW    = RW + 1;
	localparam int WCMP  = (WW > DIM_W) ? WW : DIM_W;
	localparam int HCMP  = (HW > DIM_W) ? HW : DIM_W;
	localparam int TIW   = WW + HW;
	localparam int SUM_W = ((TIW + 8 > ADDR_W) ? TIW + 8 : ADDR_W) + 1;

	// input stage
	logic            valid_s1;
	logic [PIX_W-1:0] color_s1;
	logic            first_s1;

	// state
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] acc_q;
	logic [1:0]       pib_q;

	// output stage
	logic              out_valid_q;
	logic [PIX_W-1:0]  byte_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic              last_s2;

	logic s2_free, s1_adv, in_acc;

	assign s2_free = !out_valid_q || byte_out.ready;
	assign s1_adv  = valid_s1 && s2_free;
	assign pixel_in.ready = !valid_s1 || s2_free;
	assign in_acc  = pixel_in.valid && pixel_in.ready;

	// effective geometry
	logic [WCMP-1:0] w_cmp;
	logic [HCMP-1:0] h_cmp;
	logic [WW-1:0]   w_eff, w_full, tiles_x;
	logic [HW-1:0]   h_eff, h_full;
	logic [1:0]      lbpp;
	logic [2:0]      ltw, lth;

	always_comb begin
		w_cmp = WCMP'(cfg.image_width);
		h_cmp = HCMP'(cfg.image_height);
		if (w_cmp == '0)
			w_eff = WW'(1);
		else if (w_cmp > WCMP'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = w_cmp[WW-1:0];
		if (h_cmp == '0)
			h_eff = HW'(1);
		else if (h_cmp > HCMP'(MAX_HEIGHT))
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = h_cmp[HW-1:0];
		lbpp    = depth_log2(cfg.pixel_depth_mode);
		ltw     = cfg.tile_width_is_16 ? 3'd4 : 3'd3;
		lth     = cfg.tile_height_is_16 ? 3'd4 : 3'd3;
		tiles_x = w_eff >> ltw;
		w_full  = tiles_x << ltw;
		h_full  = (h_eff >> lth) << lth;
	end

	// per pixel work
	logic [CW-1:0]     col;
	logic [RW-1:0]     row;
	logic [WW-1:0]     col_inc;
	logic [HW-1:0]     row_inc;
	logic [CW-1:0]     col_nx;
	logic [RW-1:0]     row_nx;
	logic              kept, emit;
	logic [1:0]        slot, slot_mask;
	logic [PIX_W-1:0]  color_m, acc_nx;
	logic [3:0]        used_bits, shamt;
	logic [TIW-1:0]    tile_index;
	logic [3:0]        tb_shift, col_low, row_low;
	logic [10:0]       in_tile_bits;
	logic [SUM_W-1:0]  addr_sum;
	logic              last_c;

	always_comb begin
		col = first_s1 ? '0 : col_q;
		row = first_s1 ? '0 : row_q;
		kept = (WW'(col) < w_full) && (HW'(row) < h_full);

		slot_mask = (lbpp == 2'd1) ? 2'd3 : ((lbpp == 2'd2) ? 2'd1 : 2'd0);
		slot      = col[1:0] & slot_mask;
		emit      = kept && (slot == slot_mask);

		color_m   = color_s1 & PIX_W'((9'd1 << (4'd1 << lbpp)) - 9'd1);
		used_bits = (4'(slot) + 4'd1) << lbpp;
		shamt     = 4'd8 - used_bits;
		if (slot == 2'd0)
			acc_nx = color_m << shamt;
		else
			acc_nx = acc_q | (color_m << shamt);

		tile_index = TIW'(row >> lth) * TIW'(tiles_x) + TIW'(col >> ltw);
		tb_shift   = 4'(ltw) + 4'(lth) + 4'(lbpp) - 4'd3;
		col_low    = 4'(col) & ((4'd1 << ltw) - 4'd1);
		row_low    = 4'(row) & ((4'd1 << lth) - 4'd1);
		in_tile_bits = ((11'(row_low) << ltw) + 11'(col_low)) << lbpp;
		addr_sum   = SUM_W'(HEADER_BYTES) + (SUM_W'(tile_index) << tb_shift)
			+ SUM_W'(in_tile_bits >> 3);
		last_c     = (HW'(row) == h_full - HW'(1)) && (WW'(col) == w_full - WW'(1));

		col_inc = WW'(col) + WW'(1);
		row_inc = HW'(row) + HW'(1);
		col_nx  = col_inc[CW-1:0];
		row_nx  = row;
		if (col_inc >= w_eff) begin
			col_nx = '0;
			row_nx = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			acc_q       <= '0;
			pib_q       <= '0;
		end else begin
			if (pixel_in.ready)
				valid_s1 <= pixel_in.valid;
			if (s2_free)
				out_valid_q <= valid_s1 && emit;
			if (s1_adv) begin
				col_q <= col_nx;
				row_q <= row_nx;
				if (kept) begin
					acc_q <= acc_nx;
					pib_q <= (slot + 2'd1) & slot_mask;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			color_s1 <= pixel_in.pixel_color;
			first_s1 <= pixel_in.first_pixel;
		end
		if (s1_adv) begin
			byte_s2 <= acc_nx;
			addr_s2 <= addr_sum[ADDR_W-1:0];
			last_s2 <= last_c;
		end
	end

	assign byte_out.valid        = out_valid_q;
	assign byte_out.byte_value   = byte_s2;
	assign byte_out.byte_address = addr_s2;
	assign byte_out.last_byte    = last_s2;

	`ASSERT_PROP(a_accept_frees_stage, clk, arst_n, in_acc && valid_s1 |-> s1_adv)
	`ASSERT_PROP(a_no_result_no_valid, clk, arst_n, s1_adv && !emit |=> !out_valid_q)
	`ASSERT_PROP(a_emit_closes_byte, clk, arst_n, s1_adv && emit |=> pib_q == 2'd0)
	`ASSERT_NEVER(a_valid_without_input, clk, arst_n, out_valid_q && !$past(valid_s1)
		&& $past(s2_free))
endmodule

[rtl/raster_to_tile_pixel_packer_top.sv]
// Top level of the raster to tile pixel packer.
`timescale 1ns / 1ps
// Usage:
//   pixel_in  : one indexed pixel per transaction in raster order; first_pixel
//               marks the top-left pixel and restarts the position counters.
//   byte_out  : one transaction per completed packed byte, with its offset in
//               the tile-ordered image (after a 2-byte header) and a flag on
//               the byte that completes the last full tile.
//   cfg port  : cfg_we/cfg_index/cfg_wdata write one register per cycle;
//               write only while no pixel is in flight.
// A byte passes the input register and then the result register before it is
//   presented on byte_out after the transaction of its last pixel.
// Throughput: one pixel per cycle while byte_out is not stalled; the counter update, one tile-index
//   multiply and the address add sit between the two registers.
// Pixels of partial edge tiles are consumed and produce nothing.
// Reset clears the pipeline, counters and accumulator and loads the default
//   configuration (4 bpp, 8x8 tiles, 64x64 image).
// When byte_out stalls, the result register holds and pixel_in keeps accepting
//   until the input register is also occupied.
module raster_to_tile_pixel_packer_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rtp_pkg::CFG_W-1:0]     cfg_wdata,
	rtp_px_if.sink                        pixel_in,
	rtp_byte_if.source                    byte_out
);
	import rtp_pkg::*;

	cfg_t cfg;

	rtp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rtp_pack_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pixel_in (pixel_in),
		.byte_out (byte_out)
	);
endmodule

[test/raster_to_tile_pixel_packer_top_tb.sv]
`timescale 1ns / 1ps
// Raster to tile pixel packer bench: random configs and frames checked against a tile address model.

typedef struct packed {
	logic [rtp_pkg::PIX_W-1:0]  value;
	logic [rtp_pkg::ADDR_W-1:0] address;
	logic                       last;
} tile_byte_t;

function automatic int unsigned fit_dim(logic [rtp_pkg::DIM_W-1:0] v, int unsigned lim);
	if (v == '0)
		return 1;
	if (32'(v) > lim)
		return lim;
	return 32'(v);
endfunction

class tile_byte_board;
	int unsigned max_w, max_h;
	logic [1:0] depth_mode;
	logic wide_tiles, tall_tiles;
	logic [rtp_pkg::DIM_W-1:0] width_reg, height_reg;
	int unsigned col, row;
	logic [7:0] acc;
	tile_byte_t expected[$];
	int unsigned mismatches, bytes_checked, last_flags;

	function new(int unsigned mw, int unsigned mh);
		max_w = mw;
		max_h = mh;
		depth_mode = rtp_pkg::DEPTH_4BPP;
		wide_tiles = 0;
		tall_tiles = 0;
		width_reg = 64;
		height_reg = 64;
		col = 0;
		row = 0;
		acc = 0;
	endfunction

	function void write_reg(logic [rtp_pkg::CFG_IDX_W-1:0] idx, logic [rtp_pkg::CFG_W-1:0] data);
		case (idx)
			rtp_pkg::REG_PIXEL_DEPTH_MODE:  depth_mode = data[1:0];
			rtp_pkg::REG_TILE_WIDTH_IS_16:  wide_tiles = data[0];
			rtp_pkg::REG_TILE_HEIGHT_IS_16: tall_tiles = data[0];
			rtp_pkg::REG_IMAGE_WIDTH:       width_reg = data;
			rtp_pkg::REG_IMAGE_HEIGHT:      height_reg = data;
			default: ;
		endcase
	endfunction

	// returns 1 when the pixel falls inside a full tile
	function bit note_pixel(logic [7:0] color, logic first);
		int unsigned w, h, tw, th, bpp, ppb, tiles_x, span_x, span_y, c, slot;
		int unsigned tile_idx, tile_bytes, in_tile;
		bit used;
		tile_byte_t b;
		w = fit_dim(width_reg, max_w);
		h = fit_dim(height_reg, max_h);
		tw = wide_tiles ? 16 : 8;
		th = tall_tiles ? 16 : 8;
		bpp = (depth_mode == rtp_pkg::DEPTH_2BPP) ? 2 : (depth_mode == rtp_pkg::DEPTH_4BPP) ? 4 : 8;
		ppb = 8 / bpp;
		tiles_x = w / tw;
		span_x = tiles_x * tw;
		span_y = (h / th) * th;
		c = color & ((1 << bpp) - 1);
		if (first) begin
			col = 0;
			row = 0;
		end
		used = (col < span_x) && (row < span_y);
		if (used) begin
			slot = col & (ppb - 1);
			if (slot == 0)
				acc = 8'(c << (8 - bpp));
			else
				acc = acc | 8'(c << (8 - bpp * (slot + 1)));
			if (slot == ppb - 1) begin
				tile_idx = (row / th) * tiles_x + col / tw;
				tile_bytes = tw * th * bpp / 8;
				in_tile = ((row % th) * tw + col % tw) * bpp / 8;
				b.value = acc;
				b.address = rtp_pkg::ADDR_W'(rtp_pkg::HEADER_BYTES + tile_idx * tile_bytes + in_tile);
				b.last = (row == span_y - 1) && (col == span_x - 1);
				expected.push_back(b);
			end
		end
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h)
				row = 0;
		end
		return used;
	endfunction

	function void check_byte(logic [7:0] value, logic [rtp_pkg::ADDR_W-1:0] address, logic last);
		tile_byte_t e;
		bytes_checked++;
		if (expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected byte value %h addr %0d last %0d", $realtime, value,
					address, last);
		end else begin
			e = expected.pop_front();
			if (e.value !== value || e.address !== address || e.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: byte mismatch: expected value %h addr %0d last %0d, got value %h addr %0d last %0d",
						$realtime, e.value, e.address, e.last, value, address, last);
			end else if (last) begin
				last_flags++;
			end
		end
	endfunction
endclass

module raster_to_tile_pixel_packer_top_tb;
	import rtp_pkg::*;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIXEL_TARGET = 1900;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam logic [1:0] DEPTH_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	rtp_px_if px_if();
	rtp_byte_if byte_if();

	raster_to_tile_pixel_packer_top #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pixel_in(px_if),
		.byte_out(byte_if)
	);

	tile_byte_board board;
	bit quiet;
	bit hold_req;
	int unsigned used_pixels, sent_pixels, phases, idle_cycles;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (px_if.valid && px_if.ready) || (byte_if.valid && byte_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: timeout, no transaction for %0d cycles", $realtime, IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// byte receiver
	initial begin
		int unsigned gap;
		byte_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 8);
			if (hold_req) begin
				hold_req = 0;
				gap = HOLD_CYCLES;
			end
			if (gap != 0) begin
				byte_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_if.ready <= 1'b1;
			do @(posedge clk); while (!byte_if.valid);
			board.check_byte(byte_if.byte_value, byte_if.byte_address, byte_if.last_byte);
		end
	end

	task automatic send_pixel(input logic [7:0] color, input logic first);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			px_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		px_if.valid <= 1'b1;
		px_if.pixel_color <= color;
		px_if.first_pixel <= first;
		do @(posedge clk); while (!px_if.ready);
		if (board.note_pixel(color, first))
			used_pixels++;
		sent_pixels++;
	endtask

	task automatic settle();
		px_if.valid <= 1'b0;
		while (board.expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic configure(input logic [1:0] mode, input logic wide, input logic tall,
		input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		write_reg(REG_PIXEL_DEPTH_MODE, CFG_W'(mode));
		write_reg(REG_TILE_WIDTH_IS_16, CFG_W'(wide));
		write_reg(REG_TILE_HEIGHT_IS_16, CFG_W'(tall));
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input int unsigned count, input bit with_first, input bit mid_pause);
		for (int unsigned i = 0; i < count; i++) begin
			if (mid_pause && i == count / 2 && i != 0) begin
				px_if.valid <= 1'b0;
				do @(posedge clk); while (board.expected.size() != 0);
			end
			send_pixel(8'($urandom), with_first && i == 0);
		end
	endtask

	task automatic send_noise(input int unsigned count);
		repeat (count)
			send_pixel(8'($urandom), $urandom_range(0, 7) == 0);
	endtask

	function automatic logic [DIM_W-1:0] pick_dim(input int unsigned typ_max);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return DIM_W'(1024);
				2: return DIM_W'(2047);
				default: return DIM_W'($urandom_range(1025, 2047));
			endcase
		end
		if (r < 3)
			return DIM_W'($urandom_range(1, 7));
		return DIM_W'($urandom_range(8, typ_max));
	endfunction

	initial begin
		logic [1:0] mode;
		logic wide, tall;
		logic [DIM_W-1:0] w, h;
		int unsigned area, kind;
		bit pause;

		board = new(MAX_WIDTH, MAX_HEIGHT);
		px_if.valid = 1'b0;
		px_if.pixel_color = '0;
		px_if.first_pixel = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default config, restart after a completed byte
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'h0F, 1'b1);
		send_pixel(8'hF0, 1'b0);
		settle();
		// spare depth code packs 8 bits
		configure(DEPTH_SPARE, 1'b0, 1'b0, 11'd8, 11'd8);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h01, 1'b0);
		settle();
		configure(DEPTH_2BPP, 1'b1, 1'b1, 11'd16, 11'd16);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFE, 1'b0);
		send_pixel(8'h01, 1'b0);
		settle();
		// zero size acts as one pixel: smaller than a tile, all dropped
		configure(DEPTH_8BPP, 1'b0, 1'b0, 11'd0, 11'd0);
		send_pixel(8'hAA, 1'b1);
		send_pixel(8'h55, 1'b0);
		settle();
		// oversized image saturates
		configure(DEPTH_4BPP, 1'b1, 1'b0, 11'h7FF, 11'h7FF);
		send_frame(10, 1'b1, 1'b0);
		settle();
		// column now past the narrower width: dropped, then wraps to row one
		configure(DEPTH_8BPP, 1'b0, 1'b0, 11'd8, 11'd16);
		send_frame(3, 1'b0, 1'b0);
		settle();

		while (sent_pixels < PIXEL_TARGET && phases < 500) begin
			mode = 2'($urandom_range(0, 3));
			wide = 1'($urandom_range(0, 1));
			tall = 1'($urandom_range(0, 1));
			w = pick_dim(40);
			h = pick_dim(24);
			configure(mode, wide, tall, w, h);
			quiet = ($urandom_range(0, 3) == 0);
			if (phases == 0) begin
				quiet = 1;
				hold_req = 1;
			end
			pause = (phases == 1) || ($urandom_range(0, 5) == 0);
			area = fit_dim(w, MAX_WIDTH) * fit_dim(h, MAX_HEIGHT);
			if (area > 400)
				area = 400;
			if (area > PIXEL_TARGET - sent_pixels)
				area = PIXEL_TARGET - sent_pixels;
			kind = $urandom_range(0, 9);
			if (kind < 6)
				repeat ($urandom_range(1, 2)) send_frame(area, 1'b1, pause);
			else if (kind < 8)
				send_frame($urandom_range(1, area), 1'($urandom_range(0, 1)), pause);
			else
				send_noise($urandom_range(5, 60));
			settle();
			phases++;
		end
		quiet = 0;
		repeat (10) @(posedge clk);

		$display("Run covered %0d pixels (%0d inside full tiles) over %0d random configurations,",
			sent_pixels, used_pixels, phases);
		$display("with %0d packed bytes checked, %0d of them closing the last tile; %0d mismatches.",
			board.bytes_checked, board.last_flags, board.mismatches);
		if (board.mismatches == 0 && board.expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

[raster_to_tile_pixel_packer_top.f]
+incdir+rtl
rtl/rtp_pkg.sv
rtl/rtp_px_if.sv
rtl/rtp_byte_if.sv
rtl/rtp_cfg_regs.sv
rtl/rtp_pack_core.sv
rtl/raster_to_tile_pixel_packer_top.sv
test/raster_to_tile_pixel_packer_top_tb.sv
